FILE: rtl/core/ucp_pkg.sv
// Shared types and character constants for the URI component parser.
`timescale 1ns / 1ps

package ucp_pkg;

    // Parse phase, held across bytes of one URI
    typedef enum logic [2:0] {
        PH_SCHEME   = 3'd0,
        PH_RESOURCE = 3'd1,
        PH_QUERY    = 3'd2,
        PH_FRAGMENT = 3'd3,
        PH_ERROR    = 3'd4
    } phase_t;

    // Tag given to each byte
    typedef enum logic [2:0] {
        PART_SCHEME   = 3'd0,
        PART_RESOURCE = 3'd1,
        PART_QUERY    = 3'd2,
        PART_SEP      = 3'd3,
        PART_IGNORED  = 3'd4
    } part_t;

    // Delimiter that was expected when a byte is rejected
    typedef enum logic [1:0] {
        DELIM_COLON = 2'd0,
        DELIM_QMARK = 2'd1,
        DELIM_HASH  = 2'd2
    } delim_t;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DOT     = 8'h2E;

    // One result item
    typedef struct packed {
        part_t       part;
        logic        error_here;
        delim_t      expected_delim;
        logic [7:0]  bad_char;
        logic        uri_ok;
        logic        last_out;
    } result_t;

endpackage

FILE: rtl/core/ucp_step.sv
// Per-byte classification and phase transition for the URI component parser.
`timescale 1ns / 1ps

module ucp_step
(
    input  ucp_pkg::phase_t  phase,
    input  logic [7:0]       byte_in,
    input  logic             has_byte,
    input  logic             end_of_uri,
    output ucp_pkg::phase_t  phase_next,
    output ucp_pkg::result_t res
);

    logic unreserved;
    logic query_char;

    assign unreserved = byte_in inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                                        ucp_pkg::CH_DASH, ucp_pkg::CH_UNDER,
                                        ucp_pkg::CH_DOT, ucp_pkg::CH_TILDE};
    assign query_char = unreserved ||
                        (byte_in inside {ucp_pkg::CH_COLON, ucp_pkg::CH_AMP,
                                         ucp_pkg::CH_EQUAL, ucp_pkg::CH_SLASH,
                                         ucp_pkg::CH_PERCENT});

    always_comb
    begin
        ucp_pkg::phase_t ph;
        ph                 = phase;
        res.part           = ucp_pkg::PART_IGNORED;
        res.error_here     = 1'b0;
        res.expected_delim = ucp_pkg::DELIM_COLON;
        res.bad_char       = 8'h00;
        res.uri_ok         = 1'b0;
        res.last_out       = end_of_uri;

        if (has_byte)
        begin
            case (phase)
                ucp_pkg::PH_SCHEME:
                begin
                    if (unreserved)
                    begin
                        res.part = ucp_pkg::PART_SCHEME;
                    end
                    else if (byte_in == ucp_pkg::CH_COLON)
                    begin
                        res.part = ucp_pkg::PART_SEP;
                        ph       = ucp_pkg::PH_RESOURCE;
                    end
                    else
                    begin
                        res.error_here     = 1'b1;
                        res.expected_delim = ucp_pkg::DELIM_COLON;
                        res.bad_char       = byte_in;
                        ph                 = ucp_pkg::PH_ERROR;
                    end
                end
                ucp_pkg::PH_RESOURCE:
                begin
                    if (unreserved)
                    begin
                        res.part = ucp_pkg::PART_RESOURCE;
                    end
                    else if (byte_in == ucp_pkg::CH_QMARK)
                    begin
                        res.part = ucp_pkg::PART_SEP;
                        ph       = ucp_pkg::PH_QUERY;
                    end
                    else
                    begin
                        res.error_here     = 1'b1;
                        res.expected_delim = ucp_pkg::DELIM_QMARK;
                        res.bad_char       = byte_in;
                        ph                 = ucp_pkg::PH_ERROR;
                    end
                end
                ucp_pkg::PH_QUERY:
                begin
                    if (query_char)
                    begin
                        res.part = ucp_pkg::PART_QUERY;
                    end
                    else if (byte_in == ucp_pkg::CH_HASH)
                    begin
                        res.part = ucp_pkg::PART_SEP;
                        ph       = ucp_pkg::PH_FRAGMENT;
                    end
                    else
                    begin
                        res.error_here     = 1'b1;
                        res.expected_delim = ucp_pkg::DELIM_HASH;
                        res.bad_char       = byte_in;
                        ph                 = ucp_pkg::PH_ERROR;
                    end
                end
                ucp_pkg::PH_FRAGMENT:
                begin
                    ph = ucp_pkg::PH_FRAGMENT;
                end
                default:
                begin
                    ph = ucp_pkg::PH_ERROR;
                end
            endcase
        end

        // End of string: report validity and restart at the scheme
        if (end_of_uri)
        begin
            res.uri_ok = ph inside {ucp_pkg::PH_SCHEME, ucp_pkg::PH_RESOURCE,
                                    ucp_pkg::PH_QUERY, ucp_pkg::PH_FRAGMENT};
            ph         = ucp_pkg::PH_SCHEME;
        end

        phase_next = ph;
    end

endmodule

FILE: rtl/core/uri_component_parser_core.sv
// Top level of the streaming URI component parser.
`timescale 1ns / 1ps

// Streaming URI checker: one byte per input transfer, one result transfer per
// input transfer, in order. Each byte is tagged as scheme, resource, query,
// separator or ignored; the first illegal byte is reported with the delimiter
// that was expected, after which bytes are ignored until the transfer with
// tlast, whose result carries uri_ok and returns the parser to the scheme.
// A lone tlast transfer with tuser low is an empty URI. Throughput is one
// transfer per clock for as long as the result side keeps tready high; a
// low m_axis_tready stalls the input once both registers hold an item.
// The byte is captured in the input register on its transfer, then moves
// through the classification logic into the result register once that
// slot is free or being drained. The only loop is the 3-bit phase register,
// updated each time an item moves into the result register.

module uri_component_parser_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_uri

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] error_here, [2:1] expected_delim,
                                        // [10:3] bad_char, [11] uri_ok, [15:12] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] part
    output logic        m_axis_tlast    // last_out
);

    // Input register
    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_has_reg;
    logic             in_last_reg;

    // Result register
    logic             out_valid_reg, out_valid_next;
    ucp_pkg::result_t out_res_reg;

    // Parse state
    ucp_pkg::phase_t  phase_reg, phase_next;

    ucp_pkg::result_t step_res;
    logic             s_xfer;
    logic             advance;

    // Move the held byte into the result register when that slot is free
    // or is being drained in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    ucp_step u_step
    (
        .phase      (phase_reg),
        .byte_in    (in_byte_reg),
        .has_byte   (in_has_reg),
        .end_of_uri (in_last_reg),
        .phase_next (phase_next),
        .res        (step_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= ucp_pkg::PH_SCHEME;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    // Payload: capture on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_byte_reg <= s_axis_tdata;
            in_has_reg  <= s_axis_tuser;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.part;
    assign m_axis_tlast  = out_res_reg.last_out;
    assign m_axis_tdata  = {4'b0000, out_res_reg.uri_ok, out_res_reg.bad_char,
                            out_res_reg.expected_delim, out_res_reg.error_here};

`ifndef SYNTHESIS
    // A held error result that does not close the URI leaves the parser in error
    a_error_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.error_here && !out_res_reg.last_out
        |-> phase_reg == ucp_pkg::PH_ERROR)
        else $error("phase not in error after a rejected byte");

    // A held end-of-URI result means the parser is back at the scheme
    a_end_restart : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.last_out |-> phase_reg == ucp_pkg::PH_SCHEME)
        else $error("phase not restarted after end of URI");

    // Validity is only reported on the closing result
    a_ok_on_last : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.uri_ok |-> out_res_reg.last_out)
        else $error("uri_ok raised on a result that is not last");

    // A rejected byte is never tagged as a component
    a_error_tag : assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_res.error_here |=> out_res_reg.part == ucp_pkg::PART_IGNORED)
        else $error("rejected byte carries a component tag");
`endif

endmodule
